// File: hw/rtl/hotspot_servo_tracker_unit_defines.svh
// assertion macros shared by the tracker rtl
// no dependencies; included by files that carry concurrent checks
`ifndef HOTSPOT_SERVO_TRACKER_UNIT_DEFINES_SVH
`define HOTSPOT_SERVO_TRACKER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define HST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("hotspot tracker check failed");

// next-cycle implication, disabled while reset is asserted
`define HST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("hotspot tracker check failed");

`endif

// File: hw/rtl/hst_pkg.sv
// shared widths, parameter defaults, register indexes and types for the hotspot servo tracker
// no dependencies
package hst_pkg;

	localparam int unsigned FRAME_PIXELS_DEF = 768;
	localparam int unsigned ROW_WIDTH_DEF    = 32;

	localparam int unsigned TEMP_W = 16;
	localparam int unsigned IDX_W  = 10;
	localparam int unsigned POS_W  = 8;
	localparam int unsigned CRD_W  = 5;
	// full coordinate width, one bit wider than a pixel index
	localparam int unsigned CW_W   = IDX_W + 1;

	typedef enum logic [2:0] {
		REG_BAND    = 3'd0,
		REG_OFFSET  = 3'd1,
		REG_HMIN    = 3'd2,
		REG_HMAX    = 3'd3,
		REG_VMIN    = 3'd4,
		REG_VMAX    = 3'd5,
		REG_COL_CTR = 3'd6,
		REG_ROW_CTR = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [POS_W-1:0] lo;
		logic [POS_W-1:0] hi;
	} servo_lim_t;

endpackage

// File: hw/rtl/hst_coord.sv
// column and rounded-up row of a pixel index, by constant reciprocal multiply
// depends on hst_pkg
module hst_coord
	import hst_pkg::*;
#(
	parameter int unsigned ROW_WIDTH = ROW_WIDTH_DEF
) (
	input  logic [IDX_W-1:0] idx,
	output logic [CW_W-1:0]  x,
	output logic [CW_W-1:0]  y
);

	// exact floor division for numerators below 2^11 and divisors up to 64
	localparam int unsigned SHIFT  = 18;
	localparam int unsigned RECIP  = ((1 << SHIFT) + ROW_WIDTH - 1) / ROW_WIDTH;
	localparam int unsigned N_W    = CW_W;
	localparam int unsigned PROD_W = N_W + SHIFT;

	logic [N_W-1:0]    n_lo, n_hi;
	logic [PROD_W-1:0] p_lo, p_hi;
	logic [N_W-1:0]    q_lo, q_hi, rem;

	always_comb begin
		n_lo = {1'b0, idx};
		n_hi = n_lo + N_W'(ROW_WIDTH - 1);
		p_lo = PROD_W'(n_lo) * PROD_W'(RECIP);
		p_hi = PROD_W'(n_hi) * PROD_W'(RECIP);
		q_lo = p_lo[PROD_W-1:SHIFT];
		q_hi = p_hi[PROD_W-1:SHIFT];
		rem  = n_lo - N_W'(q_lo * N_W'(ROW_WIDTH));
		x    = rem;
		y    = q_hi;
	end

endmodule

// File: hw/rtl/hst_servo.sv
// one-step servo compare update in the given direction, clamped to the limit on that side
// depends on hst_pkg
module hst_servo
	import hst_pkg::*;
(
	input  logic [POS_W-1:0] cur,
	input  servo_lim_t       lim,
	input  logic             down,
	output logic [POS_W-1:0] nxt
);

	logic [POS_W-1:0] v;

	always_comb begin
		if (down) begin
			v   = (cur != '0) ? cur - POS_W'(1) : cur;
			nxt = (v < lim.lo) ? lim.lo : v;
		end else begin
			v   = (cur != '1) ? cur + POS_W'(1) : cur;
			nxt = (v > lim.hi) ? lim.hi : v;
		end
	end

endmodule

// File: hw/rtl/hotspot_servo_tracker_unit.sv
// hotspot servo tracker top level: input stage, frame maximum, hotspot and servo state
// depends on hst_pkg, hst_coord, hst_servo and hotspot_servo_tracker_unit_defines.svh
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------------------
//  in       | in_valid / in_stall | temperature, pixel_index, last_pixel
//  out      | out_valid/out_stall | horizontal_position, vertical_position,
//           |                     | hotspot_index, hotspot_x, hotspot_y
//  cfg      | cfg_we              | cfg_index, cfg_data (write only)
//
// one pixel beat per cycle while in_stall is low; a result leaves after its last_pixel beat
// the input register feeds the frame/hotspot update, which loads the result registers
// a last_pixel beat waits in the input register only while an earlier result is stalled;
// other pixel beats keep flowing during an output stall
// reset is asynchronous and restores register defaults and servo/hotspot state
`include "hotspot_servo_tracker_unit_defines.svh"

module hotspot_servo_tracker_unit
	import hst_pkg::*;
#(
	parameter int unsigned FRAME_PIXELS = FRAME_PIXELS_DEF,
	parameter int unsigned ROW_WIDTH    = ROW_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [TEMP_W-1:0] temperature,
	input  logic [IDX_W-1:0]         pixel_index,
	input  logic                     last_pixel,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [POS_W-1:0]         horizontal_position,
	output logic [POS_W-1:0]         vertical_position,
	output logic [IDX_W-1:0]         hotspot_index,
	output logic [CRD_W-1:0]         hotspot_x,
	output logic [CRD_W-1:0]         hotspot_y,
	input  logic                     cfg_we,
	input  logic [2:0]               cfg_index,
	input  logic [11:0]              cfg_data
);

	localparam int unsigned EXT_W = TEMP_W + 2;
	localparam logic signed [EXT_W-1:0] TEMP_SAT = EXT_W'(32767);

	// configuration
	logic [11:0]      band_q, offset_q;
	logic [POS_W-1:0] hmin_q, hmax_q, vmin_q, vmax_q;
	logic [CRD_W-1:0] col_ctr_q, row_ctr_q;

	// input register
	logic                     s1_valid;
	logic signed [TEMP_W-1:0] temp_s1;
	logic [IDX_W-1:0]         idx_s1;
	logic [CW_W-1:0]          x_s1, y_s1;
	logic                     last_s1;

	// frame and tracking state
	logic signed [TEMP_W-1:0] fmax_q;
	logic [IDX_W-1:0]         fmax_idx_q;
	logic [CW_W-1:0]          fmax_x_q, fmax_y_q;
	logic                     open_q;
	logic signed [TEMP_W-1:0] ref_q;
	logic [IDX_W-1:0]         trk_idx_q;
	logic [CW_W-1:0]          trk_x_q, trk_y_q;
	logic [POS_W-1:0]         hcmp_q, vcmp_q;
	logic                     out_valid_q;

	logic [CW_W-1:0]  in_x, in_y;
	logic             accept, advance, fire;
	logic             counted, take, open_nxt, move;
	logic signed [TEMP_W-1:0] mx;
	logic [IDX_W-1:0]         mi;
	logic [CW_W-1:0]          mxx, myy;
	logic signed [EXT_W-1:0]  mx_ext, ref_ext, band_ext, off_ext, sum_ext;
	logic signed [TEMP_W-1:0] ref_nxt;
	logic [IDX_W-1:0]         trk_idx_n;
	logic [CW_W-1:0]          trk_x_n, trk_y_n;
	logic [POS_W-1:0]         h_nxt, v_nxt;
	servo_lim_t               h_lim, v_lim;

	hst_coord #(
		.ROW_WIDTH(ROW_WIDTH)
	) u_coord (
		.idx(pixel_index),
		.x  (in_x),
		.y  (in_y)
	);

	// a last beat can only move on once the result register is free
	assign advance  = !last_s1 || !out_valid_q || !out_stall;
	assign fire     = s1_valid && advance;
	assign in_stall = s1_valid && !advance;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		counted  = ({1'b0, idx_s1} < (IDX_W + 1)'(FRAME_PIXELS));
		take     = counted && (!open_q || (temp_s1 > fmax_q));
		open_nxt = open_q || counted;
		mx       = take ? temp_s1 : fmax_q;
		mi       = take ? idx_s1 : fmax_idx_q;
		mxx      = take ? x_s1 : fmax_x_q;
		myy      = take ? y_s1 : fmax_y_q;

		mx_ext   = EXT_W'(mx);
		ref_ext  = EXT_W'(ref_q);
		band_ext = $signed({{(EXT_W-12){1'b0}}, band_q});
		off_ext  = $signed({{(EXT_W-12){1'b0}}, offset_q});
		move     = (mx_ext > ref_ext + band_ext) || (mx_ext < ref_ext - band_ext);
		sum_ext  = mx_ext + off_ext;
		ref_nxt  = (sum_ext > TEMP_SAT) ? TEMP_SAT[TEMP_W-1:0] : sum_ext[TEMP_W-1:0];

		if (open_nxt && move) begin
			trk_idx_n = mi;
			trk_x_n   = mxx;
			trk_y_n   = myy;
		end else begin
			trk_idx_n = trk_idx_q;
			trk_x_n   = trk_x_q;
			trk_y_n   = trk_y_q;
		end

		h_lim = '{lo: hmin_q, hi: hmax_q};
		v_lim = '{lo: vmin_q, hi: vmax_q};
	end

	hst_servo u_servo_h (
		.cur (hcmp_q),
		.lim (h_lim),
		.down(trk_x_n > CW_W'(col_ctr_q)),
		.nxt (h_nxt)
	);

	hst_servo u_servo_v (
		.cur (vcmp_q),
		.lim (v_lim),
		.down(trk_y_n > CW_W'(row_ctr_q)),
		.nxt (v_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_q    <= 12'd32;
			offset_q  <= 12'd80;
			hmin_q    <= POS_W'(25);
			hmax_q    <= POS_W'(125);
			vmin_q    <= POS_W'(50);
			vmax_q    <= POS_W'(100);
			col_ctr_q <= CRD_W'(16);
			row_ctr_q <= CRD_W'(12);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_BAND:    band_q    <= cfg_data;
				REG_OFFSET:  offset_q  <= cfg_data;
				REG_HMIN:    hmin_q    <= cfg_data[POS_W-1:0];
				REG_HMAX:    hmax_q    <= cfg_data[POS_W-1:0];
				REG_VMIN:    vmin_q    <= cfg_data[POS_W-1:0];
				REG_VMAX:    vmax_q    <= cfg_data[POS_W-1:0];
				REG_COL_CTR: col_ctr_q <= cfg_data[CRD_W-1:0];
				REG_ROW_CTR: row_ctr_q <= cfg_data[CRD_W-1:0];
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (accept) begin
			s1_valid <= 1'b1;
		end else if (advance) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			temp_s1 <= temperature;
			idx_s1  <= pixel_index;
			x_s1    <= in_x;
			y_s1    <= in_y;
			last_s1 <= last_pixel;
		end
	end

	// frame maximum is only read after the first counted pixel wrote it
	always_ff @(posedge clk) begin
		if (fire && !last_s1) begin
			fmax_q <= mx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmax_idx_q  <= '0;
			fmax_x_q    <= '0;
			fmax_y_q    <= '0;
			open_q      <= 1'b0;
			ref_q       <= TEMP_W'(16);
			trk_idx_q   <= '0;
			trk_x_q     <= '0;
			trk_y_q     <= '0;
			hcmp_q      <= POS_W'(75);
			vcmp_q      <= POS_W'(75);
			out_valid_q <= 1'b0;
		end else begin
			if (fire && last_s1) begin
				open_q      <= 1'b0;
				trk_idx_q   <= trk_idx_n;
				trk_x_q     <= trk_x_n;
				trk_y_q     <= trk_y_n;
				hcmp_q      <= h_nxt;
				vcmp_q      <= v_nxt;
				out_valid_q <= 1'b1;
				if (open_nxt) begin
					ref_q <= ref_nxt;
				end
			end else begin
				if (fire) begin
					fmax_idx_q <= mi;
					fmax_x_q   <= mxx;
					fmax_y_q   <= myy;
					open_q     <= open_nxt;
				end
				if (!out_stall) begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	assign out_valid           = out_valid_q;
	assign horizontal_position = hcmp_q;
	assign vertical_position   = vcmp_q;
	assign hotspot_index       = trk_idx_q;
	assign hotspot_x           = trk_x_q[CRD_W-1:0];
	assign hotspot_y           = trk_y_q[CRD_W-1:0];

	`HST_ASSERT_IMP(a_stall_only_when_held, clk, arst_n, in_stall, s1_valid && last_s1)
	`HST_ASSERT_NXT(a_frame_closes, clk, arst_n, fire && last_s1, !open_q && out_valid_q)
	`HST_ASSERT_NXT(a_result_drains, clk, arst_n,
		out_valid_q && !out_stall && !(fire && last_s1), !out_valid_q)
	`HST_ASSERT_IMP(a_tracked_in_frame, clk, arst_n, 1'b1,
		{1'b0, trk_idx_q} < (IDX_W + 1)'(FRAME_PIXELS))

endmodule
